[src/dma8_pkg.sv]
// shared types, codes and field widths of the eight-channel dma engine
package dma8_pkg;

    localparam int CHANNELS_MAX = 8;
    localparam int CHANNELS_DEF = 8;

    // command kinds carried on the request side tuser
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_START = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    // per-channel register offsets
    localparam logic [3:0] OFF_CTL     = 4'h0;
    localparam logic [3:0] OFF_BBASE   = 4'h1;
    localparam logic [3:0] OFF_AOFF_LO = 4'h2;
    localparam logic [3:0] OFF_AOFF_HI = 4'h3;
    localparam logic [3:0] OFF_ABANK   = 4'h4;
    localparam logic [3:0] OFF_CNT_LO  = 4'h5;
    localparam logic [3:0] OFF_CNT_HI  = 4'h6;
    localparam logic [3:0] OFF_IBANK   = 4'h7;
    localparam logic [3:0] OFF_TPTR_LO = 4'h8;
    localparam logic [3:0] OFF_TPTR_HI = 4'h9;
    localparam logic [3:0] OFF_LINE    = 4'hA;
    localparam logic [3:0] OFF_SPARE_A = 4'hB;
    localparam logic [3:0] OFF_SPARE_B = 4'hF;

    // control register bits
    localparam int CTL_FIXED = 3;
    localparam int CTL_DEC   = 4;
    localparam int CTL_FROMB = 7;

    // wait timer steps
    localparam logic [15:0] TIMER_START = 16'd16;
    localparam logic [15:0] TIMER_STEP  = 16'd2;
    localparam logic [15:0] TIMER_BYTE  = 16'd6;
    localparam logic [15:0] TIMER_DONE  = 16'd14; // byte plus channel finish, from zero

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // b address offset for a transfer mode and its position in the pattern
    function automatic logic [1:0] pattern_offset(input logic [2:0] mode,
                                                  input logic [1:0] pidx);
        logic [1:0] res;
        res = 2'd0;
        case (mode)
            3'd1, 3'd5: res = {1'b0, pidx[0]};
            3'd3, 3'd7: res = {1'b0, pidx[1]};
            3'd4:       res = pidx;
            default:    res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

[src/eight_channel_dma_engine.sv]
// top level of the eight-channel dma engine: register file, scheduler and request output
//
//  channel   | direction | tdata bits (low first)                         | tuser
//  ----------+-----------+------------------------------------------------+-------------
//  s (cmd)   | in        | reg_address[6:0], write_data[14:7], 0 pad      | func[1:0]
//  m (res)   | out       | read_data[7:0], from_b[8], a_address[32:9],    | xfer_valid[0]
//            |           | b_address[40:33], channel_number[43:41],       |
//            |           | busy_res[44], 0 pad                            |
//
// one command per cycle sustained while the result is taken; each command is held in the input
// register and then passes into the result register
// the per-command work is a priority pick over the active bits, one register
// file read and the counter steps, all between those two registers
// reset (synchronous, active low) loads every channel register with all ones,
// clears active bits, pattern positions, the wait timer and busy
// a stalled result register holds the input register, which in turn drops
// tready; a waiting result does not block a new command while it is taken
module eight_channel_dma_engine #(
    parameter int CHANNELS = dma8_pkg::CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // reg_address[6:0], write_data[14:7], zero pad
    input  logic [dma8_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[1:0]
    input  logic [dma8_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // read_data[7:0], from_b[8], a_address[32:9], b_address[40:33],
    // channel_number[43:41], busy_res[44], zero pad
    output logic [dma8_pkg::M_TDATA_W-1:0] o_m_tdata,
    // xfer_valid[0]
    output logic [dma8_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import dma8_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // input register
    logic        r_in_valid;
    t_func       r_in_func;
    logic [6:0]  r_in_addr;
    logic [7:0]  r_in_data;

    // result register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_out_xfer;

    // channel register file
    logic [7:0]  r_ctl   [CHANNELS];
    logic [7:0]  r_bbase [CHANNELS];
    logic [15:0] r_aoff  [CHANNELS];
    logic [7:0]  r_abank [CHANNELS];
    logic [15:0] r_cnt   [CHANNELS];
    logic [7:0]  r_ibank [CHANNELS];
    logic [15:0] r_tptr  [CHANNELS];
    logic [7:0]  r_line  [CHANNELS];
    logic [7:0]  r_spare [CHANNELS];
    logic [1:0]  r_pidx  [CHANNELS];

    // scheduler state
    logic [CHANNELS-1:0] r_active;
    logic [15:0]         r_timer;
    logic                r_busy;
    logic [CHANNELS-1:0] n_active;
    logic [15:0]         n_timer;
    logic                n_busy;

    logic                 w_adv;
    logic                 w_accept;
    logic [2:0]           w_addr_ch;
    logic [3:0]           w_off;
    logic                 w_addr_ok;
    logic                 w_pick_found;
    logic [CH_W-1:0]      w_pick_idx;
    logic [CH_W-1:0]      w_rd_idx;
    logic                 w_tick_busy;
    logic                 w_move;
    logic [15:0]          w_cnt_dec;
    logic                 w_done;
    logic [16:0]          w_start_sum;
    logic [7:0]           w_read_data;
    logic [1:0]           w_pat;
    logic [7:0]           w_b_addr;
    logic [7:0]           w_ctl;
    logic [M_TDATA_W-1:0] w_res_data;

    // stage handshake: the input register moves on when the result slot is free
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_addr_ch = r_in_addr[6:4];
    assign w_off     = r_in_addr[3:0];
    assign w_addr_ok = ({1'b0, w_addr_ch} < 4'(CHANNELS));

    // lowest active channel wins
    always_comb begin
        w_pick_found = 1'b0;
        w_pick_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (r_active[i]) begin
                w_pick_found = 1'b1;
                w_pick_idx   = CH_W'(i);
            end
        end
    end

    // one read address into the register file: the picked channel on a tick
    assign w_rd_idx = (r_in_func == FUNC_TICK) ? w_pick_idx : w_addr_ch[CH_W-1:0];
    assign w_ctl    = r_ctl[w_rd_idx];

    always_comb begin
        w_read_data = 8'd0;
        if (w_addr_ok) begin
            case (w_off)
                OFF_CTL:     w_read_data = w_ctl;
                OFF_BBASE:   w_read_data = r_bbase[w_rd_idx];
                OFF_AOFF_LO: w_read_data = r_aoff[w_rd_idx][7:0];
                OFF_AOFF_HI: w_read_data = r_aoff[w_rd_idx][15:8];
                OFF_ABANK:   w_read_data = r_abank[w_rd_idx];
                OFF_CNT_LO:  w_read_data = r_cnt[w_rd_idx][7:0];
                OFF_CNT_HI:  w_read_data = r_cnt[w_rd_idx][15:8];
                OFF_IBANK:   w_read_data = r_ibank[w_rd_idx];
                OFF_TPTR_LO: w_read_data = r_tptr[w_rd_idx][7:0];
                OFF_TPTR_HI: w_read_data = r_tptr[w_rd_idx][15:8];
                OFF_LINE:    w_read_data = r_line[w_rd_idx];
                OFF_SPARE_A,
                OFF_SPARE_B: w_read_data = r_spare[w_rd_idx];
                default:     w_read_data = 8'd0;
            endcase
        end
    end

    // a tick with the timer run down moves one byte for the picked channel
    assign w_tick_busy = (r_in_func == FUNC_TICK) && r_busy;
    assign w_move      = w_tick_busy && (r_timer == 16'd0) && w_pick_found;
    assign w_cnt_dec   = r_cnt[w_rd_idx] - 16'd1;
    assign w_done      = (w_cnt_dec == 16'd0);
    assign w_pat       = pattern_offset(w_ctl[2:0], r_pidx[w_rd_idx]);
    assign w_b_addr    = r_bbase[w_rd_idx] + {6'd0, w_pat};
    assign w_start_sum = {1'b0, r_timer} + {1'b0, TIMER_START};

    // scheduler next state
    always_comb begin
        n_active = r_active;
        n_timer  = r_timer;
        n_busy   = r_busy;
        case (r_in_func)
            FUNC_START: begin
                n_active = r_in_data[CHANNELS-1:0];
                n_busy   = |r_in_data[CHANNELS-1:0];
                if (n_busy) begin
                    // saturate at full scale
                    n_timer = w_start_sum[16] ? 16'hFFFF : w_start_sum[15:0];
                end
            end
            FUNC_TICK: begin
                if (r_busy) begin
                    if (r_timer != 16'd0) begin
                        n_timer = (r_timer >= TIMER_STEP) ? (r_timer - TIMER_STEP) : 16'd0;
                    end else if (!w_pick_found) begin
                        n_busy = 1'b0;
                    end else begin
                        // timer is zero here, so the additions cannot saturate
                        n_timer = w_done ? TIMER_DONE : TIMER_BYTE;
                        if (w_done) begin
                            n_active[w_pick_idx] = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result word: read data on a read, the move fields on a move, busy always
    always_comb begin
        w_res_data = '0;
        if (r_in_func == FUNC_READ) begin
            w_res_data[7:0] = w_read_data;
        end
        if (w_move) begin
            w_res_data[8]     = w_ctl[CTL_FROMB];
            w_res_data[32:9]  = {r_abank[w_rd_idx], r_aoff[w_rd_idx]};
            w_res_data[40:33] = w_b_addr;
            w_res_data[43:41] = 3'(w_pick_idx);
        end
        w_res_data[44] = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_func <= t_func'(i_s_tuser);
            r_in_addr <= i_s_tdata[6:0];
            r_in_data <= i_s_tdata[14:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_xfer <= w_move;
            r_out_data <= w_res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_timer  <= 16'd0;
            r_busy   <= 1'b0;
        end else if (w_adv) begin
            r_active <= n_active;
            r_timer  <= n_timer;
            r_busy   <= n_busy;
        end
    end

    // register file: bus writes and per-move address and count steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ctl[i]   <= 8'hFF;
                r_bbase[i] <= 8'hFF;
                r_aoff[i]  <= 16'hFFFF;
                r_abank[i] <= 8'hFF;
                r_cnt[i]   <= 16'hFFFF;
                r_ibank[i] <= 8'hFF;
                r_tptr[i]  <= 16'hFFFF;
                r_line[i]  <= 8'hFF;
                r_spare[i] <= 8'hFF;
                r_pidx[i]  <= 2'd0;
            end
        end else if (w_adv) begin
            if (r_in_func == FUNC_WRITE && w_addr_ok) begin
                case (w_off)
                    OFF_CTL:     r_ctl[w_rd_idx]         <= r_in_data;
                    OFF_BBASE:   r_bbase[w_rd_idx]       <= r_in_data;
                    OFF_AOFF_LO: r_aoff[w_rd_idx][7:0]   <= r_in_data;
                    OFF_AOFF_HI: r_aoff[w_rd_idx][15:8]  <= r_in_data;
                    OFF_ABANK:   r_abank[w_rd_idx]       <= r_in_data;
                    OFF_CNT_LO:  r_cnt[w_rd_idx][7:0]    <= r_in_data;
                    OFF_CNT_HI:  r_cnt[w_rd_idx][15:8]   <= r_in_data;
                    OFF_IBANK:   r_ibank[w_rd_idx]       <= r_in_data;
                    OFF_TPTR_LO: r_tptr[w_rd_idx][7:0]   <= r_in_data;
                    OFF_TPTR_HI: r_tptr[w_rd_idx][15:8]  <= r_in_data;
                    OFF_LINE:    r_line[w_rd_idx]        <= r_in_data;
                    OFF_SPARE_A,
                    OFF_SPARE_B: r_spare[w_rd_idx]       <= r_in_data;
                    default: begin
                    end
                endcase
            end
            if (w_move) begin
                // a count of zero wraps, giving a full 64k bytes
                r_cnt[w_rd_idx]  <= w_cnt_dec;
                r_pidx[w_rd_idx] <= w_done ? 2'd0 : (r_pidx[w_rd_idx] + 2'd1);
                if (!w_ctl[CTL_FIXED]) begin
                    r_aoff[w_rd_idx] <= w_ctl[CTL_DEC] ? (r_aoff[w_rd_idx] - 16'd1)
                                                       : (r_aoff[w_rd_idx] + 16'd1);
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_xfer;

    // an active channel can only exist while the engine is busy
    a_active_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_active) |-> r_busy)
        else $error("active channel while engine idle");

    // a start with a nonempty mask leaves the engine busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_func == FUNC_START && (|r_in_data[CHANNELS-1:0])) |=> r_busy)
        else $error("start did not set busy");

    // a byte move reloads the timer from zero
    a_move_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_move) |=> (r_timer == TIMER_BYTE || r_timer == TIMER_DONE))
        else $error("timer not reloaded after a move");

    // a move request in the result always reports the engine busy
    a_move_reports_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_xfer) |-> r_out_data[44])
        else $error("move request with busy clear");

endmodule
